### rtl/core/assert_macros.svh
// Assertion macros shared by the core RTL.
// No dependencies; expects clock and reset in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error(msg);

`endif

### rtl/core/ecs_pkg.sv
// Shared constants, register indexes, sequencer states and divider structs
// for the charge/spark step core. No dependencies.
package ecs_pkg;

   localparam int FRAC_BITS      = 16;
   localparam int WORD_BITS      = 32;
   localparam int CHARGE_BITS    = 48;
   localparam int DIV_SHIFT      = WORD_BITS - FRAC_BITS;
   localparam int DIV_HIGH_BITS  = CHARGE_BITS - DIV_SHIFT;
   localparam int KEEP_BITS      = FRAC_BITS + 1;
   localparam int TALLY_BITS     = 16;
   localparam int DRIVE_BITS     = 21;
   localparam int STEP_BITS      = 16;
   localparam int OUT_BITS       = 32;
   localparam int REQ_DATA_BITS  = 40;
   localparam int RSP_DATA_BITS  = 4 * OUT_BITS;
   localparam int CSR_INDEX_BITS = 3;

   // two quotient bits per cycle
   localparam int DIV_STEPS      = WORD_BITS / 2;
   localparam int DIV_COUNT_BITS = $clog2(DIV_STEPS);

   localparam logic [CSR_INDEX_BITS-1:0] CSR_BELT_TOP_SPEED     = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BELT_TOP_CURRENT   = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPHERE_CAPACITANCE = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LEAK_RESISTANCE    = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BREAKDOWN_VOLTAGE  = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DISCHARGE_KEEP     = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARK_HOLD         = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RATE_WINDOW        = 3'd7;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SPEED,
      ST_CURRENT,
      ST_WAIT_VB,
      ST_WAIT_LEAK,
      ST_GAIN,
      ST_LOSS,
      ST_UPDATE,
      ST_VOLT_GO,
      ST_WAIT_VOLT,
      ST_KEEP_HI,
      ST_KEEP_LO,
      ST_SPARK,
      ST_SPARK_GO,
      ST_WAIT_SPARK,
      ST_WINDOW,
      ST_WINDOW_CMP,
      ST_WAIT_RATE,
      ST_OUTPUT
   } state_type;

   typedef struct packed {
      logic                   start;
      logic [CHARGE_BITS-1:0] dividend;
      logic [WORD_BITS-1:0]   divisor;
   } div_req_type;

   typedef struct packed {
      logic                 busy;
      logic                 done;
      logic [WORD_BITS-1:0] quotient;
   } div_rsp_type;

endpackage

### rtl/core/electrostatic_charge_spark_step_core.sv
// Belt charger and spark gap step core: one request word per time step,
// one response word per step. Depends on ecs_pkg, ecs_div, assert_macros.svh.
//
// One request word is taken at a time; req_tready is high only while the
// sequencer is idle. A step runs through one shared 32x17 multiplier and one
// shared divider that yields two quotient bits per cycle, or the whole
// quotient in a single step when it saturates. The response sits in an
// output register until taken, and the next word is accepted no earlier
// than the cycle after the response is loaded. Configuration is written
// through the csr_ port; the user must write it only while the core is idle,
// which the core itself does not enforce. There is no read-back.
module electrostatic_charge_spark_step_core import ecs_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   // drive_level [20:0], step_time [36:21], zero pad to 40 bits
   input  logic [REQ_DATA_BITS-1:0]  req_tdata,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // belt_speed [31:0], sphere_voltage [63:32], sphere_charge [95:64],
   // spark_rate [127:96]
   output logic [RSP_DATA_BITS-1:0]  rsp_tdata,
   // spark_fired [0]
   output logic                      rsp_tuser,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [WORD_BITS-1:0]      csr_wdata
);

   `include "assert_macros.svh"

   localparam logic [KEEP_BITS-1:0] ONE_FX = KEEP_BITS'(1) << FRAC_BITS;
   localparam int MUL_BITS = WORD_BITS + KEEP_BITS;

   // configuration
   logic [WORD_BITS-1:0] top_speed_ff, top_current_ff, capacitance_ff, resistance_ff;
   logic [WORD_BITS-1:0] breakdown_ff, hold_time_ff, window_ff;
   logic [KEEP_BITS-1:0] keep_ff;

   // architectural state
   logic [CHARGE_BITS-1:0] charge_ff, charge_in;
   logic [WORD_BITS-1:0]   hold_ff, hold_in;
   logic [TALLY_BITS-1:0]  tally_ff, tally_in;
   logic [WORD_BITS-1:0]   elapsed_ff, elapsed_in;
   logic [WORD_BITS-1:0]   rate_ff, rate_in;

   // per-step working registers
   state_type              state_ff, state_in;
   logic [KEEP_BITS-1:0]   drive_ff, drive_in;
   logic [STEP_BITS-1:0]   dt_ff, dt_in;
   logic [WORD_BITS-1:0]   speed_ff, speed_in;
   logic [WORD_BITS-1:0]   current_ff, current_in;
   logic [WORD_BITS-1:0]   leak_ff, leak_in;
   logic [WORD_BITS-1:0]   gain_ff, gain_in;
   logic [WORD_BITS-1:0]   loss_ff, loss_in;
   logic [WORD_BITS-1:0]   volt_ff, volt_in;
   logic [CHARGE_BITS-1:0] khi_ff, khi_in;
   logic [KEEP_BITS-1:0]   klo_ff, klo_in;
   logic                   fired_ff, fired_in;

   // response register
   logic                     rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_BITS-1:0] rsp_tdata_ff, rsp_tdata_in;
   logic                     rsp_tuser_ff, rsp_tuser_in;

   // shared units
   logic [WORD_BITS-1:0]   mul_a;
   logic [KEEP_BITS-1:0]   mul_b;
   logic [MUL_BITS-1:0]    mul_prod;
   logic [WORD_BITS:0]     mul_shift;
   div_req_type            div_req;
   div_rsp_type            div_rsp;

   // misc combinational
   logic [DRIVE_BITS-1:0]  raw_drive;
   logic [KEEP_BITS-1:0]   keep_sat;
   logic [CHARGE_BITS:0]   sum, diff;
   logic [WORD_BITS:0]     elapsed_sum;
   logic [WORD_BITS-1:0]   window_fix;
   logic [OUT_BITS-1:0]    charge_out;

   ecs_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         top_speed_ff   <= WORD_BITS'(655360);
         top_current_ff <= WORD_BITS'(655360);
         capacitance_ff <= WORD_BITS'(655360);
         resistance_ff  <= WORD_BITS'(3276800);
         breakdown_ff   <= WORD_BITS'(19660800);
         keep_ff        <= KEEP_BITS'(6554);
         hold_time_ff   <= WORD_BITS'(3277);
         window_ff      <= WORD_BITS'(65536);
      end else if (csr_we) begin
         case (csr_index)
            CSR_BELT_TOP_SPEED:     top_speed_ff   <= csr_wdata;
            CSR_BELT_TOP_CURRENT:   top_current_ff <= csr_wdata;
            CSR_SPHERE_CAPACITANCE: capacitance_ff <= csr_wdata;
            CSR_LEAK_RESISTANCE:    resistance_ff  <= csr_wdata;
            CSR_BREAKDOWN_VOLTAGE:  breakdown_ff   <= csr_wdata;
            CSR_DISCHARGE_KEEP:     keep_ff        <= csr_wdata[KEEP_BITS-1:0];
            CSR_SPARK_HOLD:         hold_time_ff   <= csr_wdata;
            CSR_RATE_WINDOW:        window_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign keep_sat = (keep_ff > ONE_FX) ? ONE_FX : keep_ff;
   assign raw_drive = req_tdata[DRIVE_BITS-1:0];

   // shared multiplier, operands picked by the sequencer
   always_comb begin
      case (state_ff)
         ST_SPEED:   begin mul_a = top_speed_ff;   mul_b = drive_ff; end
         ST_CURRENT: begin mul_a = top_current_ff; mul_b = drive_ff; end
         ST_GAIN:    begin mul_a = current_ff;     mul_b = KEEP_BITS'(dt_ff); end
         ST_LOSS:    begin mul_a = leak_ff;        mul_b = KEEP_BITS'(dt_ff); end
         ST_KEEP_HI: begin
            mul_a = charge_ff[CHARGE_BITS-1:FRAC_BITS];
            mul_b = keep_sat;
         end
         ST_KEEP_LO: begin
            mul_a = WORD_BITS'(charge_ff[FRAC_BITS-1:0]);
            mul_b = keep_sat;
         end
         default:    begin mul_a = '0; mul_b = '0; end
      endcase
   end

   assign mul_prod  = MUL_BITS'(mul_a) * MUL_BITS'(mul_b);
   assign mul_shift = mul_prod[MUL_BITS-1:FRAC_BITS];

   always_comb begin
      state_in      = state_ff;
      charge_in     = charge_ff;
      hold_in       = hold_ff;
      tally_in      = tally_ff;
      elapsed_in    = elapsed_ff;
      rate_in       = rate_ff;
      drive_in      = drive_ff;
      dt_in         = dt_ff;
      speed_in      = speed_ff;
      current_in    = current_ff;
      leak_in       = leak_ff;
      gain_in       = gain_ff;
      loss_in       = loss_ff;
      volt_in       = volt_ff;
      khi_in        = khi_ff;
      klo_in        = klo_ff;
      fired_in      = fired_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;

      div_req.start    = 1'b0;
      div_req.dividend = charge_ff;
      div_req.divisor  = capacitance_ff;

      sum         = {1'b0, charge_ff} + (CHARGE_BITS + 1)'(gain_ff);
      diff        = sum - (CHARGE_BITS + 1)'(loss_ff);
      elapsed_sum = {1'b0, elapsed_ff} + (WORD_BITS + 1)'(dt_ff);
      window_fix  = (window_ff == '0) ? WORD_BITS'(1) : window_ff;
      charge_out  = (charge_ff[CHARGE_BITS-1:OUT_BITS] != '0) ? '1
                                                               : charge_ff[OUT_BITS-1:0];

      req_tready = (state_ff == ST_IDLE);

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               // negative drive clamps to zero, above one clamps to one
               if (raw_drive[DRIVE_BITS-1])
                  drive_in = '0;
               else if (raw_drive[DRIVE_BITS-2:0] > (DRIVE_BITS - 1)'(ONE_FX))
                  drive_in = ONE_FX;
               else
                  drive_in = raw_drive[KEEP_BITS-1:0];
               dt_in    = req_tdata[DRIVE_BITS +: STEP_BITS];
               fired_in = 1'b0;
               state_in = ST_SPEED;
            end
         end
         ST_SPEED: begin
            speed_in = mul_shift[WORD_BITS-1:0];
            state_in = ST_CURRENT;
         end
         ST_CURRENT: begin
            current_in    = mul_shift[WORD_BITS-1:0];
            div_req.start = 1'b1;
            state_in      = ST_WAIT_VB;
         end
         ST_WAIT_VB: begin
            if (div_rsp.done) begin
               // voltage before the step feeds the leakage divide
               div_req.start    = 1'b1;
               div_req.dividend = CHARGE_BITS'(div_rsp.quotient);
               div_req.divisor  = resistance_ff;
               state_in         = ST_WAIT_LEAK;
            end
         end
         ST_WAIT_LEAK: begin
            if (div_rsp.done) begin
               leak_in  = div_rsp.quotient;
               state_in = ST_GAIN;
            end
         end
         ST_GAIN: begin
            gain_in  = mul_shift[WORD_BITS-1:0];
            state_in = ST_LOSS;
         end
         ST_LOSS: begin
            loss_in  = mul_shift[WORD_BITS-1:0];
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if ((CHARGE_BITS + 1)'(loss_ff) >= sum)
               charge_in = '0;
            else if (diff[CHARGE_BITS])
               charge_in = '1;
            else
               charge_in = diff[CHARGE_BITS-1:0];
            state_in = ST_VOLT_GO;
         end
         ST_VOLT_GO: begin
            div_req.start = 1'b1;
            state_in      = ST_WAIT_VOLT;
         end
         ST_WAIT_VOLT: begin
            if (div_rsp.done) begin
               volt_in = div_rsp.quotient;
               if (hold_ff != '0) begin
                  hold_in  = (hold_ff > WORD_BITS'(dt_ff)) ? hold_ff - WORD_BITS'(dt_ff) : '0;
                  state_in = ST_WINDOW;
               end else if (div_rsp.quotient >= breakdown_ff) begin
                  state_in = ST_KEEP_HI;
               end else begin
                  state_in = ST_WINDOW;
               end
            end
         end
         ST_KEEP_HI: begin
            khi_in   = mul_prod[CHARGE_BITS-1:0];
            state_in = ST_KEEP_LO;
         end
         ST_KEEP_LO: begin
            klo_in   = mul_shift[KEEP_BITS-1:0];
            state_in = ST_SPARK;
         end
         ST_SPARK: begin
            charge_in = khi_ff + CHARGE_BITS'(klo_ff);
            hold_in   = hold_time_ff;
            if (tally_ff != '1)
               tally_in = tally_ff + 1'b1;
            fired_in  = 1'b1;
            state_in  = ST_SPARK_GO;
         end
         ST_SPARK_GO: begin
            div_req.start = 1'b1;
            state_in      = ST_WAIT_SPARK;
         end
         ST_WAIT_SPARK: begin
            if (div_rsp.done) begin
               volt_in  = div_rsp.quotient;
               state_in = ST_WINDOW;
            end
         end
         ST_WINDOW: begin
            elapsed_in = elapsed_sum[WORD_BITS] ? '1 : elapsed_sum[WORD_BITS-1:0];
            state_in   = ST_WINDOW_CMP;
         end
         ST_WINDOW_CMP: begin
            if (elapsed_ff >= window_fix) begin
               // one window per step; any overshoot carries over
               elapsed_in       = elapsed_ff - window_fix;
               tally_in         = '0;
               div_req.start    = 1'b1;
               div_req.dividend = CHARGE_BITS'({tally_ff, {FRAC_BITS{1'b0}}});
               div_req.divisor  = window_ff;
               state_in         = ST_WAIT_RATE;
            end else begin
               state_in = ST_OUTPUT;
            end
         end
         ST_WAIT_RATE: begin
            if (div_rsp.done) begin
               rate_in  = div_rsp.quotient;
               state_in = ST_OUTPUT;
            end
         end
         ST_OUTPUT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {rate_ff, charge_out, volt_ff, speed_ff};
               rsp_tuser_in  = fired_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         charge_ff     <= '0;
         hold_ff       <= '0;
         tally_ff      <= '0;
         elapsed_ff    <= '0;
         rate_ff       <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         charge_ff     <= charge_in;
         hold_ff       <= hold_in;
         tally_ff      <= tally_in;
         elapsed_ff    <= elapsed_in;
         rate_ff       <= rate_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      drive_ff     <= drive_in;
      dt_ff        <= dt_in;
      speed_ff     <= speed_in;
      current_ff   <= current_in;
      leak_ff      <= leak_in;
      gain_ff      <= gain_in;
      loss_ff      <= loss_in;
      volt_ff      <= volt_in;
      khi_ff       <= khi_in;
      klo_ff       <= klo_in;
      fired_ff     <= fired_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   `ASSERT_IMPLIES(a_div_start_free, div_req.start, !div_rsp.busy,
      "divider started while still busy")
   `ASSERT_IMPLIES(a_idle_div_quiet, state_ff == ST_IDLE, !div_rsp.busy && !div_rsp.done,
      "divider active while sequencer idle")
   `ASSERT_IMPLIES(a_spark_no_hold, state_ff == ST_SPARK, hold_ff == '0,
      "spark started during hold time")

endmodule

### rtl/core/ecs_div.sv
// Shared iterative fixed-point divider: floor(a * 2^FRAC / b), saturated.
// Depends on ecs_pkg.
module ecs_div import ecs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   localparam logic [DIV_COUNT_BITS-1:0] DIV_LAST = DIV_COUNT_BITS'(DIV_STEPS - 1);

   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [WORD_BITS-1:0]      rem_ff, rem_in;
   logic [WORD_BITS-1:0]      quo_ff, quo_in;
   logic [WORD_BITS-1:0]      divisor_ff, divisor_in;
   logic [DIV_COUNT_BITS-1:0] count_ff, count_in;

   logic [WORD_BITS-1:0]     divisor_fix;
   logic [DIV_HIGH_BITS-1:0] high_part;
   logic                     overflow;
   logic [WORD_BITS:0]       r1, r1s, r2, r2s;
   logic                     ge1, ge2;

   always_comb begin
      divisor_fix = (div_req.divisor == '0) ? WORD_BITS'(1) : div_req.divisor;
      high_part   = div_req.dividend[CHARGE_BITS-1:DIV_SHIFT];
      // quotient would not fit the word
      overflow    = high_part >= DIV_HIGH_BITS'(divisor_fix);

      r1  = {rem_ff, quo_ff[WORD_BITS-1]};
      ge1 = r1 >= {1'b0, divisor_ff};
      r1s = ge1 ? (r1 - {1'b0, divisor_ff}) : r1;
      r2  = {r1s[WORD_BITS-1:0], quo_ff[WORD_BITS-2]};
      ge2 = r2 >= {1'b0, divisor_ff};
      r2s = ge2 ? (r2 - {1'b0, divisor_ff}) : r2;

      busy_in    = busy_ff;
      done_in    = 1'b0;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      count_in   = count_ff;

      if (div_req.start) begin
         divisor_in = divisor_fix;
         if (overflow) begin
            quo_in  = '1;
            done_in = 1'b1;
            busy_in = 1'b0;
         end else begin
            rem_in   = WORD_BITS'(high_part);
            quo_in   = {div_req.dividend[DIV_SHIFT-1:0], {FRAC_BITS{1'b0}}};
            count_in = DIV_LAST;
            busy_in  = 1'b1;
         end
      end else if (busy_ff) begin
         // dividend bits leave the top of quo, quotient bits enter at the bottom
         rem_in   = r2s[WORD_BITS-1:0];
         quo_in   = {quo_ff[WORD_BITS-3:0], ge1, ge2};
         count_in = count_ff - 1'b1;
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
      count_ff   <= count_in;
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule
